// ----- design/perspective_point_projection_assert.svh -----
// assertion macros for the perspective point projection block
// used by the port checker, no other dependencies
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH

// implication checked outside reset
`define PPP_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define PPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// next-cycle implication checked also during reset
`define PPP_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/ppp_pkg.sv -----
// shared constants, codes and helpers of the perspective point projection block
// no dependencies
package ppp_pkg;

  localparam int PPP_FRONT_STAGES = 5;
  localparam int PPP_DIV_STAGES   = 24;
  localparam int PPP_STAGES       = PPP_FRONT_STAGES + PPP_DIV_STAGES + 2;

  localparam logic signed [31:0] PPP_DEPTH_FLOOR = 32'sd2560;

  typedef enum logic [2:0] {
    CFG_SCREEN_CENTER = 3'd0,
    CFG_YAW_COSINE    = 3'd1,
    CFG_YAW_SINE      = 3'd2,
    CFG_PITCH_COSINE  = 3'd3,
    CFG_PITCH_SINE    = 3'd4,
    CFG_AIM_X         = 3'd5,
    CFG_AIM_Y         = 3'd6,
    CFG_EYE_DISTANCE  = 3'd7
  } cfg_index_t;

  function automatic logic [31:0] sat32(input logic signed [41:0] v);
    logic [31:0] r;
    if (v > 42'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (v < -42'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- design/perspective_point_projection.sv -----
// perspective point projection for an orbit camera, top level
// depends on ppp_pkg
//
// in_*  : world point beats, in_tdata = {world_z, world_y, world_x}, x lowest
// out_* : screen beats, out_tdata = {screen_y, screen_x}, out_tuser = depth_clamped
// cfg_* : register writes, cfg_index selects the register, taken on cfg_we
// one point per cycle is accepted while the output side keeps up
// an accepted input beat passes through five front stages, a 24 stage
// bit-per-stage divider for the scale, one multiply stage and the
// output register on its way to the output beat
// a stalled receiver holds the output beat; bubbles inside the pipe are
// filled first, so in_tready drops only once every stage holds a beat
// reset empties the pipe and loads the register defaults
// configuration must be written by the user only while the pipe is empty; the block does not enforce it
module perspective_point_projection (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,    // world_x, world_y, world_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // screen_x, screen_y
  output logic [0:0]  out_tuser,   // depth_clamped
  input  logic        cfg_we,
  input  ppp_pkg::cfg_index_t cfg_index,
  input  logic [31:0] cfg_wdata
);
  import ppp_pkg::*;

  localparam int NS = PPP_STAGES;
  localparam int ND = PPP_DIV_STAGES;
  localparam int DB = PPP_FRONT_STAGES;

  logic [31:0]        center_r;
  logic signed [15:0] yc_r, ys_r, pc_r, ps_r;
  logic signed [23:0] aim_x_r, aim_y_r;
  logic [18:0]        eye_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_r <= '0;
      yc_r     <= 16'sd16384;
      ys_r     <= '0;
      pc_r     <= 16'sd16384;
      ps_r     <= '0;
      aim_x_r  <= '0;
      aim_y_r  <= '0;
      eye_r    <= 19'd128000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCREEN_CENTER: center_r <= cfg_wdata;
        CFG_YAW_COSINE:    yc_r     <= cfg_wdata[15:0];
        CFG_YAW_SINE:      ys_r     <= cfg_wdata[15:0];
        CFG_PITCH_COSINE:  pc_r     <= cfg_wdata[15:0];
        CFG_PITCH_SINE:    ps_r     <= cfg_wdata[15:0];
        CFG_AIM_X:         aim_x_r  <= cfg_wdata[23:0];
        CFG_AIM_Y:         aim_y_r  <= cfg_wdata[23:0];
        CFG_EYE_DISTANCE:  eye_r    <= cfg_wdata[18:0];
        default:           eye_r    <= eye_r;
      endcase
    end
  end

  // stage valids and load enables
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? in_tvalid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign in_tready = en[0];

  logic signed [23:0] wx, wy, wz;
  assign wx = in_tdata[23:0];
  assign wy = in_tdata[47:24];
  assign wz = in_tdata[71:48];

  // stage 1: offset by target
  logic signed [24:0] rx1_r, ry1_r;
  logic signed [23:0] wz1_r;
  // stage 2: yaw products
  logic signed [40:0] pxc2_r, pys2_r, pxs2_r, pyc2_r;
  logic signed [23:0] wz2_r;
  // stage 3: rotated point
  logic signed [27:0] tx3_r, ty3_r;
  logic signed [23:0] wz3_r;
  // stage 4: pitch products
  logic signed [43:0] pd4_r, pp4_r;
  logic signed [27:0] tx4_r;
  logic signed [23:0] wz4_r;
  // stage 5: depth and clamp
  logic [30:0]        dv5_r;
  logic               cl5_r;
  logic signed [30:0] tp5_r;
  logic signed [27:0] tx5_r;
  logic signed [23:0] wz5_r;

  logic signed [41:0] sum_tx, sum_ty;
  logic signed [44:0] rnd_pd, rnd_pp;
  logic signed [31:0] depth;

  always_comb begin
    sum_tx = 42'(pxc2_r) - 42'(pys2_r) + 42'sd8192;
    sum_ty = 42'(pxs2_r) + 42'(pyc2_r) + 42'sd8192;
    rnd_pd = 45'(pd4_r) + 45'sd8192;
    rnd_pp = 45'(pp4_r) + 45'sd8192;
    depth  = 32'($signed(rnd_pd[44:14])) + $signed({13'b0, eye_r});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rx1_r <= 25'(wx) - 25'(aim_x_r);
      ry1_r <= 25'(wy) - 25'(aim_y_r);
      wz1_r <= wz;
    end
    if (en[1]) begin
      pxc2_r <= rx1_r * yc_r;
      pys2_r <= ry1_r * ys_r;
      pxs2_r <= rx1_r * ys_r;
      pyc2_r <= ry1_r * yc_r;
      wz2_r  <= wz1_r;
    end
    if (en[2]) begin
      tx3_r <= sum_tx[41:14];
      ty3_r <= sum_ty[41:14];
      wz3_r <= wz2_r;
    end
    if (en[3]) begin
      pd4_r <= ty3_r * pc_r;
      pp4_r <= ty3_r * ps_r;
      tx4_r <= tx3_r;
      wz4_r <= wz3_r;
    end
    if (en[4]) begin
      if (depth < PPP_DEPTH_FLOOR) begin
        dv5_r <= PPP_DEPTH_FLOOR[30:0];
        cl5_r <= 1'b1;
      end else begin
        dv5_r <= depth[30:0];
        cl5_r <= 1'b0;
      end
      tp5_r <= rnd_pp[44:14];
      tx5_r <= tx4_r;
      wz5_r <= wz4_r;
    end
  end

  // scale divider, one quotient bit per stage, msb first
  logic [34:0]        rem_r [ND];
  logic [23:0]        q_r   [ND];
  logic [30:0]        d_r   [ND];
  logic               cl_r  [ND];
  logic signed [30:0] tp_r  [ND];
  logic signed [27:0] tx_r  [ND];
  logic signed [23:0] wz_r  [ND];

  for (genvar k = 0; k < ND; k++) begin : g_div
    localparam int B = ND - 1 - k;
    logic [34:0]        rem_in;
    logic [23:0]        q_in;
    logic [30:0]        d_in;
    logic               cl_in;
    logic signed [30:0] tp_in;
    logic signed [27:0] tx_in;
    logic signed [23:0] wz_in;
    logic [54:0]        dsh;
    logic               ge;

    if (k == 0) begin : g_first
      assign rem_in = {eye_r, 16'b0};
      assign q_in   = '0;
      assign d_in   = dv5_r;
      assign cl_in  = cl5_r;
      assign tp_in  = tp5_r;
      assign tx_in  = tx5_r;
      assign wz_in  = wz5_r;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign d_in   = d_r[k-1];
      assign cl_in  = cl_r[k-1];
      assign tp_in  = tp_r[k-1];
      assign tx_in  = tx_r[k-1];
      assign wz_in  = wz_r[k-1];
    end

    assign dsh = {24'b0, d_in} << B;
    assign ge  = {20'b0, rem_in} >= dsh;

    always_ff @(posedge clk) begin
      if (en[DB+k]) begin
        rem_r[k] <= ge ? 35'({20'b0, rem_in} - dsh) : rem_in;
        q_r[k]   <= q_in | (24'(ge) << B);
        d_r[k]   <= d_in;
        cl_r[k]  <= cl_in;
        tp_r[k]  <= tp_in;
        tx_r[k]  <= tx_in;
        wz_r[k]  <= wz_in;
      end
    end
  end

  // scale products
  logic signed [52:0] mx_r;
  logic signed [48:0] mz_r;
  logic signed [54:0] mp_r;
  logic               clm_r;
  logic signed [24:0] scale;

  assign scale = $signed({1'b0, q_r[ND-1]});

  always_ff @(posedge clk) begin
    if (en[NS-2]) begin
      mx_r  <= tx_r[ND-1] * scale;
      mz_r  <= wz_r[ND-1] * scale;
      mp_r  <= tp_r[ND-1] * scale;
      clm_r <= cl_r[ND-1];
    end
  end

  // final sums and saturation
  logic signed [53:0] rmx;
  logic signed [49:0] rmz;
  logic signed [55:0] rmp;
  logic signed [41:0] sx, sy;
  logic [31:0]        sx_r, sy_r;
  logic               clo_r;

  always_comb begin
    rmx = 54'(mx_r) + 54'sd32768;
    rmz = 50'(mz_r) + 50'sd32768;
    rmp = 56'(mp_r) + 56'sd32768;
    sx  = 42'($signed(rmx[53:16])) + $signed({19'b0, center_r[15:0], 7'b0});
    sy  = $signed({19'b0, center_r[31:16], 7'b0}) - 42'($signed(rmz[49:16]))
          + 42'($signed(rmp[55:16]));
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      sx_r  <= sat32(sx);
      sy_r  <= sat32(sy);
      clo_r <= clm_r;
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = {sy_r, sx_r};
  assign out_tuser  = clo_r;

endmodule

// ----- design/ppp_checker.sv -----
// port checker for the perspective point projection block, bound to the top level
// depends on ppp_pkg and perspective_point_projection_assert.svh
`include "perspective_point_projection_assert.svh"

module ppp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [0:0]  out_tuser
);
  import ppp_pkg::*;

  `PPP_ASSERT_RST(a_reset_empty, !rst_n, !out_tvalid, "output beat right after reset")
  `PPP_ASSERT_IMPLY(a_ready_flow, out_tready, in_tready, "input stalled while output drains")
  `PPP_ASSERT_NEXT(a_hold_valid, out_tvalid && !out_tready, out_tvalid, "output beat dropped")
  `PPP_ASSERT_NEXT(a_hold_data, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser), "stalled output beat changed")

endmodule

bind perspective_point_projection ppp_checker u_ppp_checker (.*);

// ----- bench/tb_top.sv -----
// testbench for the perspective point projection block: random and directed world points,
// predicted screen beats compared in order; depends on ppp_pkg and the block's top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ppp_pkg::*;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic        clamp;
  } screen_pt_t;

  class projection_board;
    logic [31:0] center;
    longint ycos, ysin, pcos, psin, ax, ay, eye;
    screen_pt_t pending[$];
    int errors;
    int checked;

    function new();
      center = 0; ycos = 16384; ysin = 0; pcos = 16384; psin = 0;
      ax = 0; ay = 0; eye = 128000; errors = 0; checked = 0;
    endfunction

    function void set_reg(cfg_index_t idx, logic [31:0] v);
      case (idx)
        CFG_SCREEN_CENTER: center = v;
        CFG_YAW_COSINE:    ycos = longint'($signed(v[15:0]));
        CFG_YAW_SINE:      ysin = longint'($signed(v[15:0]));
        CFG_PITCH_COSINE:  pcos = longint'($signed(v[15:0]));
        CFG_PITCH_SINE:    psin = longint'($signed(v[15:0]));
        CFG_AIM_X:         ax = longint'($signed(v[23:0]));
        CFG_AIM_Y:         ay = longint'($signed(v[23:0]));
        CFG_EYE_DISTANCE:  eye = longint'({45'd0, v[18:0]});
        default: ;
      endcase
    endfunction

    function longint rnd(longint v, int s);
      return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function logic [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void note_point(logic [71:0] d);
      longint wx, wy, wz, rx, ry, tx, ty, dep, scl, cx, cy;
      screen_pt_t p;
      wx = longint'($signed(d[23:0]));
      wy = longint'($signed(d[47:24]));
      wz = longint'($signed(d[71:48]));
      rx = wx - ax;
      ry = wy - ay;
      tx = rnd(rx * ycos - ry * ysin, 14);
      ty = rnd(rx * ysin + ry * ycos, 14);
      dep = eye + rnd(ty * pcos, 14);
      p.clamp = 0;
      if (dep < 2560) begin
        dep = 2560;
        p.clamp = 1;
      end
      scl = (eye << 16) / dep;
      cx = longint'(center[15:0]) * 128;
      cy = longint'(center[31:16]) * 128;
      p.sx = clip(cx + rnd(tx * scl, 16));
      p.sy = clip(cy - rnd(wz * scl, 16) + rnd(rnd(ty * psin, 14) * scl, 16));
      pending.push_back(p);
    endfunction

    task check_beat(logic [63:0] d, logic u);
      screen_pt_t e;
      checked++;
      if (pending.size() == 0) begin
        report("beat with nothing pending", 0, d);
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e.sx) report("screen_x", e.sx, d[31:0]);
      if (d[63:32] !== e.sy) report("screen_y", e.sy, d[63:32]);
      if (u !== e.clamp) report("depth_clamped", e.clamp, u);
    endtask

    task report(string what, logic [63:0] exp_v, logic [63:0] got);
      errors++;
      if (errors <= 30) $display("mismatch %s: expected %h got %h", what, exp_v, got);
    endtask
  endclass

  logic clk = 0, rst_n = 0;
  logic in_tvalid = 0, in_tready, out_tvalid, out_tready = 0, cfg_we = 0;
  logic [71:0] in_tdata = 0;
  logic [63:0] out_tdata;
  logic [0:0] out_tuser;
  cfg_index_t cfg_index = CFG_SCREEN_CENTER;
  logic [31:0] cfg_wdata = 0;
  projection_board board = new();
  int hold_off = 0;
  bit quiet = 0;
  int sent = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  perspective_point_projection dut (.*);

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_beat(out_tdata, out_tuser[0]);
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else begin
      out_tready <= quiet || ($urandom_range(99) >= 12);
    end
  end

  task write_reg(cfg_index_t idx, logic [31:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    board.set_reg(idx, v);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task send_point(logic [71:0] d);
    while (!quiet && $urandom_range(99) < 12) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    board.note_point(d);
    sent++;
  endtask

  task drain();
    in_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (PPP_STAGES + 5) @(posedge clk);
  endtask

  function logic [23:0] rnd_coord();
    case ($urandom_range(3))
      0: return 24'($signed($urandom_range(2000)) - 1000) << 8;
      1: return 24'($urandom());
      2: return {$urandom_range(1) ? 24'h800000 : 24'h7fffff};
      default: return 24'($signed($urandom_range(200000)) - 100000);
    endcase
  endfunction

  task random_regs(bit extreme);
    write_reg(CFG_SCREEN_CENTER, extreme ? 32'hffff_ffff : $urandom());
    write_reg(CFG_YAW_COSINE, extreme ? 32'hffffc000 : 32'($signed($urandom_range(32768)) - 16384));
    write_reg(CFG_YAW_SINE, extreme ? 32'h4000 : 32'($signed($urandom_range(32768)) - 16384));
    write_reg(CFG_PITCH_COSINE, extreme ? 32'hffffc000 : $urandom());
    write_reg(CFG_PITCH_SINE, extreme ? 32'h4000 : 32'($signed($urandom_range(32768)) - 16384));
    write_reg(CFG_AIM_X, extreme ? 32'h800000 : {8'd0, rnd_coord()});
    write_reg(CFG_AIM_Y, extreme ? 32'h7fffff : {8'd0, rnd_coord()});
    write_reg(CFG_EYE_DISTANCE, extreme ? 32'd512000 : ($urandom_range(3) == 0 ?
              $urandom() : $urandom_range(512000, 12800)));
  endtask

  initial begin
    #50_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1;
    // directed: default registers, field extremes
    send_point(72'd0);
    send_point({24'h7fffff, 24'h7fffff, 24'h7fffff});
    send_point({24'h800000, 24'h800000, 24'h800000});
    send_point({24'h000100, 24'h800000, 24'h7fffff});
    send_point({24'hffffff, 24'hfe0c00, 24'h000001});
    send_point({24'h7fffff, 24'h7fffff, 24'h800000});
    drain();
    // zero distance and tiny depth
    write_reg(CFG_EYE_DISTANCE, 32'd0);
    send_point({24'h001000, 24'h002000, 24'h003000});
    drain();
    write_reg(CFG_EYE_DISTANCE, 32'd12800);
    write_reg(CFG_SCREEN_CENTER, 32'hffff_ffff);
    send_point({24'h000000, 24'hffce00, 24'h000000});
    send_point({24'h000000, 24'hffcf00, 24'h000100});
    send_point({24'h7fffff, 24'h7fffff, 24'h800000});
    drain();
    random_regs(1);
    send_point(72'd0);
    send_point({24'h7fffff, 24'h800000, 24'h7fffff});
    send_point({24'h800000, 24'h7fffff, 24'h800000});
    drain();
    // random phases; a long quiet stretch, and one long receiver hold-off
    for (int ph = 0; ph < 8; ph++) begin
      random_regs(0);
      quiet = (ph == 3);
      if (ph == 5) hold_off = 200;
      for (int i = 0; i < 100; i++) send_point({rnd_coord(), rnd_coord(), rnd_coord()});
      quiet = 0;
      drain();
    end
    $display("sent %0d points over 12 register settings, %0d beats checked",
             sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
